>>> hdl/pplr_pkg.sv
// ----------------------------------------------------------------------------
// pplr_pkg
// Shared types, codes and helpers of the periodic piecewise-linear remap.
// ----------------------------------------------------------------------------
package pplr_pkg;

   localparam int MAX_PLANES   = 16;
   localparam int POS_W        = 32;
   localparam int DIFF_W       = 34;
   localparam int MAG_W        = 34;
   localparam int PROD_W       = 2 * MAG_W;
   localparam int QUOT_CAP_BIT = 40;
   localparam int QUOT_W       = QUOT_CAP_BIT + 1;
   localparam int SEG_W        = 4;
   localparam int SLOT_W       = 4;
   localparam int REGION_W     = 2;
   localparam int COUNT_W      = 5;
   localparam int BOX_W        = 31;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 31;

   localparam logic [QUOT_W-1:0] QUOT_CAP = {1'b1, {QUOT_CAP_BIT{1'b0}}};

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_MAP  = 1'b1;

   localparam logic [REGION_W-1:0] REGION_BELOW    = 2'd0;
   localparam logic [REGION_W-1:0] REGION_INTERIOR = 2'd1;
   localparam logic [REGION_W-1:0] REGION_ABOVE    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LENGTH  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SETUP,
      ST_MATH,
      ST_FIN
   } ctl_state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_RND
   } md_state_type;

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] mcand;
      logic [MAG_W-1:0] mplier;
      logic [MAG_W-1:0] divisor;
   } md_req_type;

   function automatic logic signed [DIFF_W-1:0] sext_pos(input logic [POS_W-1:0] v);
      return $signed({{(DIFF_W-POS_W){v[POS_W-1]}}, v});
   endfunction

   function automatic logic [MAG_W-1:0] mag_of(input logic signed [DIFF_W-1:0] v);
      logic signed [DIFF_W-1:0] n;
      n = -v;
      return v[DIFF_W-1] ? MAG_W'(n) : MAG_W'(v);
   endfunction

endpackage

>>> hdl/pplr_ram.sv
// ----------------------------------------------------------------------------
// pplr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pplr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/pplr_muldiv.sv
// ----------------------------------------------------------------------------
// pplr_muldiv
// Bit-serial multiply, restoring divide, round half up and cap of the quotient.
// ----------------------------------------------------------------------------
module pplr_muldiv
   import pplr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  md_req_type        md_req,
   output logic              md_done,
   output logic [QUOT_W-1:0] md_quot
);

   localparam int STEP_W = $clog2(PROD_W);

   md_state_type      state_ff, state_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0] mcand_ff, mcand_in;
   logic [MAG_W-1:0]  mplier_ff, mplier_in;
   logic [MAG_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;

   logic [MAG_W:0]    rem_sh;
   logic [MAG_W:0]    rem_twice;
   logic [PROD_W-1:0] quot_rnd;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MD_IDLE: if (md_req.start) state_in = MD_MUL;
         MD_MUL:  if (step_ff == STEP_W'(MAG_W - 1)) state_in = MD_DIV;
         MD_DIV:  if (step_ff == STEP_W'(PROD_W - 1)) state_in = MD_RND;
         MD_RND:  state_in = MD_IDLE;
         default: state_in = MD_IDLE;
      endcase
   end

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      step_in   = step_ff;
      done_in   = 1'b0;
      quot_in   = quot_ff;
      rem_sh    = {rem_ff, acc_ff[PROD_W-1]};
      rem_twice = {rem_ff, 1'b0};
      quot_rnd  = acc_ff + PROD_W'(rem_twice >= {1'b0, div_ff});
      case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               acc_in    = '0;
               mcand_in  = PROD_W'(md_req.mcand);
               mplier_in = md_req.mplier;
               div_in    = md_req.divisor;
               rem_in    = '0;
               step_in   = '0;
            end
         end
         MD_MUL: begin
            if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
            mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[MAG_W-1:1]};
            step_in   = (step_ff == STEP_W'(MAG_W - 1)) ? '0 : step_ff + 1'b1;
         end
         MD_DIV: begin
            // shift in the next dividend bit, subtract when it fits
            if (rem_sh >= {1'b0, div_ff}) begin
               rem_in = MAG_W'(rem_sh - {1'b0, div_ff});
               acc_in = {acc_ff[PROD_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[MAG_W-1:0];
               acc_in = {acc_ff[PROD_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
         end
         MD_RND: begin
            quot_in = (quot_rnd > PROD_W'(QUOT_CAP)) ? QUOT_CAP : quot_rnd[QUOT_W-1:0];
            done_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      step_ff   <= step_in;
      quot_ff   <= quot_in;
   end

   assign md_done = done_ff;
   assign md_quot = quot_ff;

endmodule

>>> hdl/periodic_piecewise_linear_remap_top.sv
// ----------------------------------------------------------------------------
// periodic_piecewise_linear_remap_top
// Periodic piecewise-linear remap of Q16.16 coordinates over a plane table.
// ----------------------------------------------------------------------------
// A load item writes one before/after plane pair into two table RAMs and is
// taken with no result. A map item is worked on alone: the sequencer scans
// the used planes through the RAM read port, one entry per cycle, picks the
// segment, then a shared serial unit forms |d*dA| one bit per cycle, divides
// it by |dB| one quotient bit per cycle and rounds. A zero-width segment or a
// pass-through skips the serial unit. The result waits in an output register,
// so the next item is accepted while it is not yet taken. The tables come out
// of reset undefined; map only after all used slots are loaded.
// ----------------------------------------------------------------------------
module periodic_piecewise_linear_remap_top
   import pplr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [SLOT_W-1:0]     req_plane_slot,
   input  logic [POS_W-1:0]      req_plane_before,
   input  logic [POS_W-1:0]      req_plane_after,
   input  logic [POS_W-1:0]      req_position,
   input  logic                  req_last_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [POS_W-1:0]      rsp_mapped_position,
   output logic [REGION_W-1:0]   rsp_region,
   output logic [SEG_W-1:0]      rsp_segment,
   output logic                  rsp_last_out,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int IDX_W = $clog2(MAX_PLANES);
   localparam int NUM_W = $clog2(MAX_PLANES + 1);
   localparam int SUM_W = QUOT_W + 2;

   // configuration
   logic [COUNT_W-1:0] plane_count_ff;
   logic [BOX_W-1:0]   box_length_ff;

   ctl_state_type      state_ff, state_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [NUM_W-1:0]   cnt_ff, cnt_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               last_ff, last_in;
   logic [POS_W-1:0]   b0_ff, b0_in, a0_ff, a0_in;
   logic [POS_W-1:0]   prev_b_ff, prev_b_in, prev_a_ff, prev_a_in;
   logic [POS_W-1:0]   lo_b_ff, lo_b_in, lo_a_ff, lo_a_in;
   logic [POS_W-1:0]   hi_b_ff, hi_b_in, hi_a_ff, hi_a_in;
   logic               found_ff, found_in;
   logic [SEG_W-1:0]   seg_ff, seg_in;
   logic [REGION_W-1:0] region_ff, region_in;
   logic [POS_W-1:0]   alo_ff, alo_in;
   logic               neg_ff, neg_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [REGION_W-1:0] rsp_region_ff, rsp_region_in;
   logic [SEG_W-1:0]   rsp_seg_ff, rsp_seg_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               req_take;
   logic               out_free;
   logic               tab_wr_en;
   logic [IDX_W-1:0]   tab_wr_addr;
   logic [IDX_W-1:0]   tab_rd_addr;
   logic [POS_W-1:0]   rd_b, rd_a;
   md_req_type         md_req;
   logic               md_done;
   logic [QUOT_W-1:0]  md_quot;

   logic signed [DIFF_W-1:0] op_d, op_da, op_db, gap_b, gap_a;
   logic signed [SUM_W-1:0]  sum;
   logic               in_seg;
   logic [NUM_W-1:0]   num_clamp;

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // clamp plane count to 2..MAX_PLANES
   always_comb begin
      if (32'(plane_count_ff) < 2) num_clamp = NUM_W'(2);
      else if (32'(plane_count_ff) > MAX_PLANES) num_clamp = NUM_W'(MAX_PLANES);
      else num_clamp = NUM_W'(plane_count_ff);
   end

   // loads only land in idle, scans only read outside idle: no overlap
   assign tab_wr_en   = req_take && (req_action == ACT_LOAD) &&
                        (32'(req_plane_slot) < MAX_PLANES);
   assign tab_wr_addr = IDX_W'(req_plane_slot);
   assign tab_rd_addr = IDX_W'(cnt_ff);

   pplr_ram #(.WIDTH(POS_W), .DEPTH(MAX_PLANES)) u_before_ram (
      .clock   (clock),
      .wr_en   (tab_wr_en),
      .wr_addr (tab_wr_addr),
      .wr_data (req_plane_before),
      .rd_addr (tab_rd_addr),
      .rd_data (rd_b)
   );

   pplr_ram #(.WIDTH(POS_W), .DEPTH(MAX_PLANES)) u_after_ram (
      .clock   (clock),
      .wr_en   (tab_wr_en),
      .wr_addr (tab_wr_addr),
      .wr_data (req_plane_after),
      .rd_addr (tab_rd_addr),
      .rd_data (rd_a)
   );

   pplr_muldiv u_muldiv (
      .clock   (clock),
      .reset   (reset),
      .md_req  (md_req),
      .md_done (md_done),
      .md_quot (md_quot)
   );

   // segment operands, from the scan results
   always_comb begin
      gap_b = sext_pos(b0_ff) + DIFF_W'(box_length_ff) - sext_pos(prev_b_ff);
      gap_a = sext_pos(a0_ff) + DIFF_W'(box_length_ff) - sext_pos(prev_a_ff);
      if ($signed(pos_ff) >= $signed(prev_b_ff)) begin
         op_d  = sext_pos(pos_ff) - sext_pos(prev_b_ff);
         op_da = gap_a;
         op_db = gap_b;
      end else if (found_ff) begin
         op_d  = sext_pos(pos_ff) - sext_pos(lo_b_ff);
         op_da = sext_pos(hi_a_ff) - sext_pos(lo_a_ff);
         op_db = sext_pos(hi_b_ff) - sext_pos(lo_b_ff);
      end else begin
         op_d  = sext_pos(pos_ff) - sext_pos(b0_ff);
         op_da = gap_a;
         op_db = gap_b;
      end
   end

   assign in_seg = ($signed(pos_ff) >= $signed(prev_b_ff)) &&
                   ($signed(pos_ff) < $signed(rd_b));
   assign sum = neg_ff ? (SUM_W'($signed(alo_ff)) - $signed({2'b00, quot_ff}))
                       : (SUM_W'($signed(alo_ff)) + $signed({2'b00, quot_ff}));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_take && (req_action == ACT_MAP)) state_in = ST_SCAN;
         ST_SCAN:  if (cnt_ff == num_ff) state_in = ST_SETUP;
         ST_SETUP: begin
            if ((op_db == '0) || ($signed(pos_ff) < $signed(prev_b_ff) && !found_ff &&
                 $signed(pos_ff) >= $signed(b0_ff))) state_in = ST_FIN;
            else state_in = ST_MATH;
         end
         ST_MATH:  if (md_done) state_in = ST_FIN;
         ST_FIN:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      num_in    = num_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      last_in   = last_ff;
      b0_in     = b0_ff;
      a0_in     = a0_ff;
      prev_b_in = prev_b_ff;
      prev_a_in = prev_a_ff;
      lo_b_in   = lo_b_ff;
      lo_a_in   = lo_a_ff;
      hi_b_in   = hi_b_ff;
      hi_a_in   = hi_a_ff;
      found_in  = found_ff;
      seg_in    = seg_ff;
      region_in = region_ff;
      alo_in    = alo_ff;
      neg_in    = neg_ff;
      quot_in   = quot_ff;
      md_req    = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_pos_in    = rsp_pos_ff;
      rsp_region_in = rsp_region_ff;
      rsp_seg_in    = rsp_seg_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_action == ACT_MAP)) begin
               num_in   = num_clamp;
               cnt_in   = '0;
               pos_in   = req_position;
               last_in  = req_last_in;
               found_in = 1'b0;
               seg_in   = '0;
            end
         end
         ST_SCAN: begin
            // data of entry cnt-1 is on the read port
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == NUM_W'(1)) begin
               b0_in = rd_b;
               a0_in = rd_a;
            end
            if (cnt_ff > NUM_W'(1) && in_seg) begin
               found_in = 1'b1;
               seg_in   = SEG_W'(cnt_ff - NUM_W'(2));
               lo_b_in  = prev_b_ff;
               lo_a_in  = prev_a_ff;
               hi_b_in  = rd_b;
               hi_a_in  = rd_a;
            end
            if (cnt_ff != '0) begin
               prev_b_in = rd_b;
               prev_a_in = rd_a;
            end
         end
         ST_SETUP: begin
            neg_in  = op_d[DIFF_W-1] ^ op_da[DIFF_W-1] ^ op_db[DIFF_W-1];
            quot_in = '0;
            if ($signed(pos_ff) >= $signed(prev_b_ff)) begin
               region_in = REGION_ABOVE;
               seg_in    = '0;
               alo_in    = prev_a_ff;
            end else if (found_ff) begin
               region_in = REGION_INTERIOR;
               alo_in    = lo_a_ff;
            end else if ($signed(pos_ff) < $signed(b0_ff)) begin
               region_in = REGION_BELOW;
               alo_in    = a0_ff;
            end else begin
               // no rule matched: pass the coordinate through
               region_in = REGION_INTERIOR;
               seg_in    = '0;
               alo_in    = pos_ff;
            end
            if (state_in == ST_MATH) begin
               md_req.start   = 1'b1;
               md_req.mcand   = mag_of(op_d);
               md_req.mplier  = mag_of(op_da);
               md_req.divisor = mag_of(op_db);
            end
         end
         ST_MATH: begin
            if (md_done) quot_in = md_quot;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               if (sum > SUM_W'($signed(32'sh7fffffff))) rsp_pos_in = 32'h7fffffff;
               else if (sum < SUM_W'($signed(32'sh80000000))) rsp_pos_in = 32'h80000000;
               else rsp_pos_in = sum[POS_W-1:0];
               rsp_region_in = region_ff;
               rsp_seg_in    = seg_ff;
               rsp_last_in   = last_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         plane_count_ff <= COUNT_W'(2);
         box_length_ff  <= BOX_W'(65536);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable && csr_index == CSR_PLANE_COUNT) begin
            plane_count_ff <= csr_write_data[COUNT_W-1:0];
         end
         if (csr_write_enable && csr_index == CSR_BOX_LENGTH) begin
            box_length_ff <= csr_write_data[BOX_W-1:0];
         end
      end
      num_ff        <= num_in;
      cnt_ff        <= cnt_in;
      pos_ff        <= pos_in;
      last_ff       <= last_in;
      b0_ff         <= b0_in;
      a0_ff         <= a0_in;
      prev_b_ff     <= prev_b_in;
      prev_a_ff     <= prev_a_in;
      lo_b_ff       <= lo_b_in;
      lo_a_ff       <= lo_a_in;
      hi_b_ff       <= hi_b_in;
      hi_a_ff       <= hi_a_in;
      found_ff      <= found_in;
      seg_ff        <= seg_in;
      region_ff     <= region_in;
      alo_ff        <= alo_in;
      neg_ff        <= neg_in;
      quot_ff       <= quot_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_region_ff <= rsp_region_in;
      rsp_seg_ff    <= rsp_seg_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mapped_position = rsp_pos_ff;
   assign rsp_region          = rsp_region_ff;
   assign rsp_segment         = rsp_seg_ff;
   assign rsp_last_out        = rsp_last_ff;

   // a new result only comes out of the finish step
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside finish step");

   // a load item never starts a sequence
   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_action == ACT_LOAD) |=> (state_ff == ST_IDLE))
      else $error("load item left idle");

   // the serial unit reports only while the sequencer waits on it
   a_done_in_math: assert property (@(posedge clock) disable iff (reset)
      md_done |-> (state_ff == ST_MATH))
      else $error("unexpected divider completion");

endmodule

>>> sim/tb_periodic_piecewise_linear_remap_top.sv
// ----------------------------------------------------------------------------
// tb_periodic_piecewise_linear_remap_top
// Self-checking bench for the periodic piecewise-linear remap.
// ----------------------------------------------------------------------------
// Loads full plane tables, then streams map items under several plane counts
// and box lengths. A scoreboard keeps its own copy of the tables and registers,
// predicts each mapped coordinate, region and segment, and compares the
// result stream in order. The sender works in bursts, the receiver stalls on
// its own pattern and once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_periodic_piecewise_linear_remap_top;
   import pplr_pkg::*;

   typedef struct {
      logic [POS_W-1:0]    pos;
      logic [REGION_W-1:0] region;
      logic [SEG_W-1:0]    seg;
      logic                last;
   } remap_result_t;

   // Scoreboard: mirror of the plane tables and registers plus the queue of
   // remapped coordinates still owed by the block.
   class remap_scoreboard;
      logic [COUNT_W-1:0]      count_reg;
      logic [BOX_W-1:0]        box_reg;
      logic signed [POS_W-1:0] before_tab[16];
      logic signed [POS_W-1:0] after_tab[16];
      remap_result_t           owed_q[$];
      int                      errors;

      function new();
         count_reg = 2;
         box_reg   = 65536;
         errors    = 0;
         foreach (before_tab[i]) begin
            before_tab[i] = 0;
            after_tab[i]  = 0;
         end
      endfunction

      function int planes_used();
         if (count_reg < 2) return 2;
         if (count_reg > 16) return 16;
         return count_reg;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         if (idx == CSR_PLANE_COUNT) count_reg = v[COUNT_W-1:0];
         else if (idx == CSR_BOX_LENGTH) box_reg = v[BOX_W-1:0];
      endfunction

      function logic signed [POS_W-1:0] sat(longint v);
         if (v > 64'sd2147483647) return 32'h7fffffff;
         if (v < -64'sd2147483648) return 32'h80000000;
         return v[31:0];
      endfunction

      // alo + round(d * da / db), ties away from zero, quotient capped
      function logic signed [POS_W-1:0] lerp(longint alo, longint d, longint da, longint db);
         logic [127:0] prod, quo, rem, dv;
         bit neg;
         longint unsigned md, mda;
         if (db == 0) return sat(alo);
         neg  = ((d < 0) != (da < 0)) ^ (db < 0);
         md   = d < 0 ? -d : d;
         mda  = da < 0 ? -da : da;
         dv   = db < 0 ? 128'(-db) : 128'(db);
         prod = 128'(md) * 128'(mda);
         quo  = prod / dv;
         rem  = prod % dv;
         if (rem >= dv - rem) quo = quo + 1;
         if (quo > 128'(QUOT_CAP)) quo = 128'(QUOT_CAP);
         return sat(neg ? alo - longint'(quo[63:0]) : alo + longint'(quo[63:0]));
      endfunction

      function remap_result_t remap(logic [POS_W-1:0] pos, logic last);
         remap_result_t r;
         int n;
         longint p, b0, bl, a0, al, gb, ga;
         bit found;
         n  = planes_used();
         p  = longint'($signed(pos));
         b0 = before_tab[0];
         bl = before_tab[n-1];
         a0 = after_tab[0];
         al = after_tab[n-1];
         gb = b0 + longint'(box_reg) - bl;
         ga = a0 + longint'(box_reg) - al;
         r.last = last;
         r.seg  = 0;
         found  = 0;
         if (p >= bl) begin
            r.region = REGION_ABOVE;
            r.pos    = lerp(al, p - bl, ga, gb);
         end else begin
            // last matching interval wins on a table that is not increasing
            for (int j = 1; j < n; j++) begin
               if (p >= before_tab[j-1] && p < before_tab[j]) begin
                  r.seg = j - 1;
                  found = 1;
               end
            end
            if (found) begin
               r.region = REGION_INTERIOR;
               r.pos = lerp(after_tab[r.seg], p - before_tab[r.seg],
                            longint'(after_tab[r.seg+1]) - after_tab[r.seg],
                            longint'(before_tab[r.seg+1]) - before_tab[r.seg]);
            end else if (p < b0) begin
               r.region = REGION_BELOW;
               r.pos    = lerp(a0, p - b0, ga, gb);
            end else begin
               r.region = REGION_INTERIOR;
               r.pos    = pos;
            end
         end
         return r;
      endfunction

      function void note_item(logic act, logic [SLOT_W-1:0] slot, logic [POS_W-1:0] b,
                              logic [POS_W-1:0] a, logic [POS_W-1:0] pos, logic last);
         if (act == ACT_LOAD) begin
            before_tab[slot] = b;
            after_tab[slot]  = a;
         end else begin
            owed_q.push_back(remap(pos, last));
         end
      endfunction

      function void check_result(remap_result_t got);
         remap_result_t want;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected result, mapped_position %h", $time, got.pos);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         if (got.pos !== want.pos) begin
            $display("%0t: mapped_position expected %h actual %h", $time, want.pos, got.pos);
            errors++;
         end
         if (got.region !== want.region) begin
            $display("%0t: region expected %0d actual %0d", $time, want.region, got.region);
            errors++;
         end
         if (got.seg !== want.seg) begin
            $display("%0t: segment expected %0d actual %0d", $time, want.seg, got.seg);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last_out expected %b actual %b", $time, want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_stall;
   logic                  req_action = ACT_LOAD;
   logic [SLOT_W-1:0]     req_plane_slot = 0;
   logic [POS_W-1:0]      req_plane_before = 0;
   logic [POS_W-1:0]      req_plane_after = 0;
   logic [POS_W-1:0]      req_position = 0;
   logic                  req_last_in = 0;
   logic                  rsp_valid;
   logic                  rsp_stall = 0;
   logic [POS_W-1:0]      rsp_mapped_position;
   logic [REGION_W-1:0]   rsp_region;
   logic [SEG_W-1:0]      rsp_segment;
   logic                  rsp_last_out;
   logic                  csr_write_enable = 0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_PLANE_COUNT;
   logic [CSR_DATA_W-1:0] csr_write_data = 0;

   remap_scoreboard sb = new();
   int  burst_left = 0;
   bit  hold_go = 0;

   periodic_piecewise_linear_remap_top uut (.*);

   always #4 clock = ~clock;

   // Check every result taken by the receiver.
   always @(posedge clock) begin
      remap_result_t got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.pos    = rsp_mapped_position;
         got.region = rsp_region;
         got.seg    = rsp_segment;
         got.last   = rsp_last_out;
         sb.check_result(got);
      end
   end

   // Receiver stall pattern: runs of no stall, random stall and heavy stall.
   // Once, hold off for a long stretch so the block backs up into its input.
   initial begin
      int mode, len;
      bit held;
      held = 0;
      forever begin
         if (hold_go && !held) begin
            held = 1;
            rsp_stall <= 1;
            repeat (800) @(posedge clock);
         end
         mode = $urandom_range(0, 2);
         len  = $urandom_range(5, 60);
         repeat (len) begin
            rsp_stall <= (mode == 0) ? 1'b0 :
                         (mode == 1) ? 1'($urandom_range(0, 1)) :
                         ($urandom_range(0, 9) != 0);
            @(posedge clock);
         end
      end
   end

   // Offer one item in a burst; between bursts, usually insert a gap. Hold until taken.
   task automatic send_item(logic act, logic [SLOT_W-1:0] slot, logic [POS_W-1:0] b,
                            logic [POS_W-1:0] a, logic [POS_W-1:0] pos, logic last);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid        <= 1;
      req_action       <= act;
      req_plane_slot   <= slot;
      req_plane_before <= b;
      req_plane_after  <= a;
      req_position     <= pos;
      req_last_in      <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(act, slot, b, a, pos, last);
   endtask

   task automatic send_map(logic [POS_W-1:0] pos);
      send_item(ACT_MAP, $urandom, $urandom, $urandom, pos, $urandom_range(0, 1));
   endtask

   // Drop valid, drain owed results, let the block settle.
   task automatic drain();
      req_valid <= 0;
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      csr_write_enable <= 1;
      csr_index        <= idx;
      csr_write_data   <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
      csr_write_enable <= 0;
   endtask

   // Fill all 16 slots with an increasing before table; after table rises or falls.
   task automatic load_table();
      longint b, a, bstep, astep;
      int sgn;
      bstep = longint'(1) << (2 * $urandom_range(0, 13));
      astep = longint'(1) << (2 * $urandom_range(0, 13));
      sgn   = $urandom_range(0, 3) == 0 ? -1 : 1;
      b = -(longint'(1) << 30) + $urandom_range(0, 1 << 29);
      a = sgn * (-(longint'(1) << 30) + longint'($urandom_range(0, 1 << 29)));
      for (int s = 0; s < 16; s++) begin
         send_item(ACT_LOAD, s, b[31:0], a[31:0], $urandom, $urandom_range(0, 1));
         b = b + $urandom_range(1, bstep);
         a = a + sgn * longint'($urandom_range(0, astep));
      end
   endtask

   // Pick a coordinate around the planes in use, with some fully random.
   function automatic logic [POS_W-1:0] pick_position();
      int n, j;
      longint lo, hi;
      n = sb.planes_used();
      j = $urandom_range(0, n - 1);
      lo = sb.before_tab[j];
      hi = sb.before_tab[j < n - 1 ? j + 1 : j];
      case ($urandom_range(0, 9))
         0: return lo[31:0];
         1: return lo[31:0] + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
         2, 3: begin
            if (hi > lo) return 32'(lo + longint'($urandom) % (hi - lo));
            return lo[31:0];
         end
         4: return sb.before_tab[0] - $urandom_range(1, 1 << $urandom_range(0, 30));
         5: return sb.before_tab[n-1] + $urandom_range(0, 1 << $urandom_range(0, 30));
         6: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int n;
      logic [CSR_DATA_W-1:0] counts[5];
      logic [CSR_DATA_W-1:0] boxes[5];
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: four planes, box of 4.0.
      write_reg(CSR_PLANE_COUNT, 4);
      write_reg(CSR_BOX_LENGTH, 31'h40000);
      load_table();
      n = 4;
      send_map(sb.before_tab[0]);
      send_map(sb.before_tab[0] - 1);
      send_map(sb.before_tab[1]);
      send_map(sb.before_tab[n-1]);          // exactly on the last plane
      send_map(sb.before_tab[n-1] + 1);
      send_map(sb.before_tab[n-1] - 1);
      send_map(32'h80000000);
      send_map(32'h7fffffff);
      send_map(32'h0);
      send_map(32'hffffffff);
      // zero-width segment: slot 2 equals slot 1
      send_item(ACT_LOAD, 2, sb.before_tab[1], sb.after_tab[3], 32'hffffffff, 1);
      send_map(sb.before_tab[1]);
      // table not increasing: slot 1 above the last plane
      send_item(ACT_LOAD, 1, 32'h7fffffff, 32'h80000000, 32'h0, 0);
      send_map(sb.before_tab[3]);
      send_map(sb.before_tab[3] + 5);
      send_map(sb.before_tab[0] - 5);
      drain();

      // Random phases over several register settings, extremes included.
      counts = '{16, 2, 1, 31, 0};
      boxes  = '{31'h7fffffff, 31'd1, 31'd65536, 31'd0, 31'd0};
      counts[4] = $urandom_range(2, 16);
      boxes[3]  = $urandom;
      boxes[4]  = $urandom_range(1, 1 << 24);
      for (int ph = 0; ph < 5; ph++) begin
         write_reg(CSR_PLANE_COUNT, counts[ph]);
         write_reg(CSR_BOX_LENGTH, boxes[ph] == 0 ? 31'd1 : boxes[ph]);
         load_table();
         if (ph == 1) hold_go = 1;
         repeat (60) begin
            if ($urandom_range(0, 9) == 0)
               send_item(ACT_LOAD, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, 1));
            else
               send_map(pick_position());
         end
         drain();
      end

      if (sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #8000000;
      $display("FAILURE");
      $finish;
   end

endmodule
